// ===== design/mbsp_pkg.sv =====
// shared types and byte codes for the midi byte stream parser
package mbsp_pkg;

    localparam logic [7:0] STATUS_MIN   = 8'h80;
    localparam logic [7:0] SYSEX_START  = 8'hF0;
    localparam logic [7:0] MTC_QFRAME   = 8'hF1;
    localparam logic [7:0] SONG_POS     = 8'hF2;
    localparam logic [7:0] SONG_SELECT  = 8'hF3;
    localparam logic [7:0] TUNE_REQUEST = 8'hF6;
    localparam logic [7:0] SYSEX_END    = 8'hF7;
    localparam logic [7:0] REALTIME_MIN = 8'hF8;
    localparam logic [7:0] SYSEX_ABORT  = 8'hFF;

    localparam logic [1:0] LEN_ONE   = 2'd1;
    localparam logic [1:0] LEN_TWO   = 2'd2;
    localparam logic [1:0] LEN_THREE = 2'd3;

    // result queue depth, a power of two of at least four
    localparam int RES_DEPTH = 4;

    typedef enum logic [1:0] {
        KIND_FLAGS = 2'd0,
        KIND_SHORT = 2'd1,
        KIND_SYSEX = 2'd2
    } kind_t;

    typedef enum logic [3:0] {
        MODE_INIT      = 4'd0,
        MODE_NEWSTATUS = 4'd1,
        MODE_SYSEX     = 4'd2,
        MODE_SC3_1     = 4'd3,
        MODE_SC3_2     = 4'd4,
        MODE_SC2       = 4'd5,
        MODE_G3_FIRST  = 4'd6,
        MODE_G3_1      = 4'd7,
        MODE_G3_2      = 4'd8,
        MODE_G2_FIRST  = 4'd9,
        MODE_G2        = 4'd10
    } mode_t;

    typedef struct packed {
        kind_t       kind;
        logic [7:0]  status;
        logic [6:0]  data1;
        logic [6:0]  data2;
        logic [1:0]  length;
        logic        msg_err;
        logic        ovf_err;
        logic        last;
    } res_t;

    // decoded results of one word, count is 0, 1 or 2
    typedef struct packed {
        logic [1:0] count;
        res_t       first;
        res_t       second;
    } dec_out_t;

    typedef struct packed {
        logic not_empty;
        logic no_room;
    } fifo_stat_t;

    function automatic res_t make_res(kind_t k, logic [7:0] s, logic [6:0] d1,
                                      logic [6:0] d2, logic [1:0] len);
        res_t r;
        r.kind    = k;
        r.status  = s;
        r.data1   = d1;
        r.data2   = d2;
        r.length  = len;
        r.msg_err = 1'b0;
        r.ovf_err = 1'b0;
        r.last    = 1'b0;
        return r;
    endfunction

endpackage

// ===== design/mbsp_decoder.sv =====
// parse state registers and combinational byte decode
module mbsp_decoder (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              accept,
    input  logic [7:0]        rx_byte,
    input  logic              rx_overflow,
    output mbsp_pkg::dec_out_t dec
);

    mbsp_pkg::mode_t mode_reg, mode_next;
    logic [7:0] rs_reg, rs_next;
    logic [6:0] fd_reg, fd_next;
    logic [6:0] sd_reg, sd_next;
    logic [1:0] len_reg, len_next;

    logic is_status;

    // effect of taking rx_byte as a new status
    mbsp_pkg::mode_t ns_mode;
    logic [1:0]      ns_len;
    logic            ns_push;
    mbsp_pkg::res_t  ns_res;
    logic            ns_err;

    logic           push_a, push_b, err;
    mbsp_pkg::res_t res_a;
    mbsp_pkg::res_t flags_res;

    assign is_status = rx_byte >= mbsp_pkg::STATUS_MIN;

    always_comb
    begin
        ns_mode = mode_reg;
        ns_len  = len_reg;
        ns_push = 1'b0;
        ns_res  = mbsp_pkg::make_res(mbsp_pkg::KIND_SYSEX, mbsp_pkg::SYSEX_START,
                                     7'd0, 7'd0, 2'd0);
        ns_err  = 1'b0;
        unique case (rx_byte[7:4])
            4'h8, 4'h9, 4'hA, 4'hB, 4'hE:
            begin
                ns_len  = mbsp_pkg::LEN_THREE;
                ns_mode = mbsp_pkg::MODE_G3_FIRST;
            end
            4'hC, 4'hD:
            begin
                ns_len  = mbsp_pkg::LEN_TWO;
                ns_mode = mbsp_pkg::MODE_G2_FIRST;
            end
            4'hF:
            begin
                unique case (rx_byte)
                    mbsp_pkg::SYSEX_START:
                    begin
                        ns_push = 1'b1;
                        ns_mode = mbsp_pkg::MODE_SYSEX;
                    end
                    mbsp_pkg::SONG_POS:
                    begin
                        ns_len  = mbsp_pkg::LEN_THREE;
                        ns_mode = mbsp_pkg::MODE_SC3_1;
                    end
                    mbsp_pkg::MTC_QFRAME, mbsp_pkg::SONG_SELECT:
                    begin
                        ns_len  = mbsp_pkg::LEN_TWO;
                        ns_mode = mbsp_pkg::MODE_SC2;
                    end
                    mbsp_pkg::TUNE_REQUEST:
                    begin
                        ns_len  = mbsp_pkg::LEN_ONE;
                        ns_push = 1'b1;
                        ns_res  = mbsp_pkg::make_res(mbsp_pkg::KIND_SHORT,
                                                     mbsp_pkg::TUNE_REQUEST,
                                                     7'd0, 7'd0, mbsp_pkg::LEN_ONE);
                        ns_mode = mbsp_pkg::MODE_NEWSTATUS;
                    end
                    default:
                    begin
                        ns_err  = 1'b1;
                        ns_mode = mbsp_pkg::MODE_NEWSTATUS;
                    end
                endcase
            end
            default:
            begin
                // data byte, never taken as a status
                ns_err = 1'b1;
            end
        endcase
    end

    // next state
    always_comb
    begin
        mode_next = mode_reg;
        rs_next   = rs_reg;
        fd_next   = fd_reg;
        sd_next   = sd_reg;
        len_next  = len_reg;
        if (rx_byte < mbsp_pkg::REALTIME_MIN)
        begin
            unique case (mode_reg)
                mbsp_pkg::MODE_INIT:
                begin
                    if (is_status && rx_byte != mbsp_pkg::SYSEX_END)
                    begin
                        mode_next = ns_mode;
                        len_next  = ns_len;
                        rs_next   = rx_byte;
                    end
                end
                mbsp_pkg::MODE_SYSEX:
                begin
                    if (is_status && rx_byte == mbsp_pkg::SYSEX_END)
                    begin
                        mode_next = mbsp_pkg::MODE_NEWSTATUS;
                    end
                    else if (is_status)
                    begin
                        mode_next = ns_mode;
                        len_next  = ns_len;
                        rs_next   = rx_byte;
                    end
                end
                mbsp_pkg::MODE_SC3_1, mbsp_pkg::MODE_G3_FIRST, mbsp_pkg::MODE_G3_1:
                begin
                    if (is_status)
                    begin
                        mode_next = ns_mode;
                        len_next  = ns_len;
                        rs_next   = rx_byte;
                    end
                    else
                    begin
                        fd_next   = rx_byte[6:0];
                        mode_next = (mode_reg == mbsp_pkg::MODE_SC3_1) ?
                                    mbsp_pkg::MODE_SC3_2 : mbsp_pkg::MODE_G3_2;
                    end
                end
                mbsp_pkg::MODE_SC3_2, mbsp_pkg::MODE_G3_2:
                begin
                    if (is_status)
                    begin
                        mode_next = ns_mode;
                        len_next  = ns_len;
                        rs_next   = rx_byte;
                    end
                    else
                    begin
                        sd_next   = rx_byte[6:0];
                        mode_next = (mode_reg == mbsp_pkg::MODE_SC3_2) ?
                                    mbsp_pkg::MODE_NEWSTATUS : mbsp_pkg::MODE_G3_1;
                    end
                end
                mbsp_pkg::MODE_SC2, mbsp_pkg::MODE_G2_FIRST, mbsp_pkg::MODE_G2:
                begin
                    if (is_status)
                    begin
                        mode_next = ns_mode;
                        len_next  = ns_len;
                        rs_next   = rx_byte;
                    end
                    else
                    begin
                        fd_next   = rx_byte[6:0];
                        mode_next = (mode_reg == mbsp_pkg::MODE_SC2) ?
                                    mbsp_pkg::MODE_NEWSTATUS : mbsp_pkg::MODE_G2;
                    end
                end
                default:
                begin
                    if (is_status)
                    begin
                        mode_next = ns_mode;
                        len_next  = ns_len;
                        rs_next   = rx_byte;
                    end
                    else
                    begin
                        mode_next = mbsp_pkg::MODE_NEWSTATUS;
                    end
                end
            endcase
        end
    end

    // results of this word: slot a from the mode, slot b from a new status
    always_comb
    begin
        push_a = 1'b0;
        push_b = 1'b0;
        err    = 1'b0;
        res_a  = mbsp_pkg::make_res(mbsp_pkg::KIND_SHORT, rx_byte, 7'd0, 7'd0,
                                    mbsp_pkg::LEN_ONE);
        if (rx_byte >= mbsp_pkg::REALTIME_MIN)
        begin
            push_a = 1'b1;
        end
        else
        begin
            unique case (mode_reg)
                mbsp_pkg::MODE_INIT:
                begin
                    if (is_status && rx_byte != mbsp_pkg::SYSEX_END)
                    begin
                        push_b = ns_push;
                        err    = ns_err;
                    end
                end
                mbsp_pkg::MODE_SYSEX:
                begin
                    push_a = 1'b1;
                    if (!is_status)
                    begin
                        res_a = mbsp_pkg::make_res(mbsp_pkg::KIND_SYSEX, rx_byte,
                                                   7'd0, 7'd0, 2'd0);
                    end
                    else if (rx_byte == mbsp_pkg::SYSEX_END)
                    begin
                        res_a = mbsp_pkg::make_res(mbsp_pkg::KIND_SYSEX,
                                                   mbsp_pkg::SYSEX_END, 7'd0, 7'd0, 2'd0);
                    end
                    else
                    begin
                        // aborted sysex
                        res_a  = mbsp_pkg::make_res(mbsp_pkg::KIND_SYSEX,
                                                    mbsp_pkg::SYSEX_ABORT, 7'd0, 7'd0,
                                                    2'd0);
                        err    = 1'b1;
                        push_b = ns_push;
                    end
                end
                mbsp_pkg::MODE_SC3_1, mbsp_pkg::MODE_G3_FIRST:
                begin
                    if (is_status)
                    begin
                        err    = 1'b1;
                        push_b = ns_push;
                    end
                end
                mbsp_pkg::MODE_SC3_2, mbsp_pkg::MODE_G3_2:
                begin
                    if (is_status)
                    begin
                        err    = 1'b1;
                        push_b = ns_push;
                    end
                    else
                    begin
                        push_a = 1'b1;
                        res_a  = mbsp_pkg::make_res(mbsp_pkg::KIND_SHORT, rs_reg,
                                     (len_reg >= mbsp_pkg::LEN_TWO) ? fd_reg : 7'd0,
                                     (len_reg == mbsp_pkg::LEN_THREE) ? rx_byte[6:0] : 7'd0,
                                     len_reg);
                    end
                end
                mbsp_pkg::MODE_SC2, mbsp_pkg::MODE_G2_FIRST, mbsp_pkg::MODE_G2:
                begin
                    if (is_status)
                    begin
                        // running status in mode g2 takes a new status cleanly
                        err    = (mode_reg == mbsp_pkg::MODE_G2) ? ns_err : 1'b1;
                        push_b = ns_push;
                    end
                    else
                    begin
                        push_a = 1'b1;
                        res_a  = mbsp_pkg::make_res(mbsp_pkg::KIND_SHORT, rs_reg,
                                     (len_reg >= mbsp_pkg::LEN_TWO) ? rx_byte[6:0] : 7'd0,
                                     (len_reg == mbsp_pkg::LEN_THREE) ? sd_reg : 7'd0,
                                     len_reg);
                    end
                end
                mbsp_pkg::MODE_G3_1:
                begin
                    if (is_status)
                    begin
                        err    = ns_err;
                        push_b = ns_push;
                    end
                end
                default:
                begin
                    if (is_status)
                    begin
                        err    = ns_err;
                        push_b = ns_push;
                    end
                    else
                    begin
                        err = 1'b1;
                    end
                end
            endcase
        end
    end

    // pack into ordered result list
    always_comb
    begin
        flags_res  = mbsp_pkg::make_res(mbsp_pkg::KIND_FLAGS, 8'd0, 7'd0, 7'd0, 2'd0);
        dec.first  = push_a ? res_a : (push_b ? ns_res : flags_res);
        dec.second = ns_res;
        if (push_a && push_b)
        begin
            dec.count = 2'd2;
        end
        else if (push_a || push_b || err || rx_overflow)
        begin
            dec.count = 2'd1;
        end
        else
        begin
            dec.count = 2'd0;
        end
        dec.first.msg_err  = err;
        dec.first.ovf_err  = rx_overflow;
        dec.first.last     = (dec.count == 2'd1);
        dec.second.msg_err = err;
        dec.second.ovf_err = rx_overflow;
        dec.second.last    = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= mbsp_pkg::MODE_INIT;
            rs_reg   <= 8'd0;
            fd_reg   <= 7'd0;
            sd_reg   <= 7'd0;
            len_reg  <= 2'd0;
        end
        else if (accept)
        begin
            mode_reg <= mode_next;
            rs_reg   <= rs_next;
            fd_reg   <= fd_next;
            sd_reg   <= sd_next;
            len_reg  <= len_next;
        end
    end

endmodule

// ===== design/mbsp_result_fifo.sv =====
// result queue taking up to two results per word and giving one per cycle while pop is high
module mbsp_result_fifo (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic [1:0]           push_count,
    input  mbsp_pkg::dec_out_t   push_data,
    input  logic                 pop,
    output mbsp_pkg::res_t       head,
    output mbsp_pkg::fifo_stat_t stat
);

    localparam int DEPTH = mbsp_pkg::RES_DEPTH;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    mbsp_pkg::res_t mem_reg [DEPTH];
    logic [PTR_W-1:0] wptr_reg, wptr_next;
    logic [PTR_W-1:0] rptr_reg, rptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [PTR_W-1:0] wptr_plus1;

    assign wptr_plus1 = PTR_W'(wptr_reg + 1'b1);
    assign wptr_next  = PTR_W'(wptr_reg + push_count);
    assign rptr_next  = PTR_W'(rptr_reg + pop);
    assign cnt_next   = CNT_W'(cnt_reg + CNT_W'(push_count) - CNT_W'(pop));

    assign head           = mem_reg[rptr_reg];
    assign stat.not_empty = (cnt_reg != '0);
    // room for two results is kept so any word can enter
    assign stat.no_room   = (cnt_reg > CNT_W'(DEPTH - 2));

    always_ff @(posedge clk)
    begin
        if (push_count != 2'd0)
        begin
            mem_reg[wptr_reg] <= push_data.first;
        end
        if (push_count == 2'd2)
        begin
            mem_reg[wptr_plus1] <= push_data.second;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            cnt_reg  <= cnt_next;
        end
    end

endmodule

// ===== design/midi_byte_stream_parser.sv =====
// midi byte stream parser top level: one received byte per input word is decoded
// against the parse mode (running status, system common, sysex pass-through,
// realtime bypass) in the cycle it is accepted, and its zero to two result words
// go into a four-entry result queue. A byte is taken every cycle while the queue
// has two free entries, so the sustained rate is one byte per cycle when results
// are drained; a byte giving two results (sysex aborted by F0 or F6) hands them
// to the output side one at a time. The first result is registered in the queue
// and, with the queue empty, shows in the cycle after the byte is accepted.
module midi_byte_stream_parser (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] rx_byte,
    input  logic       rx_overflow,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [1:0] kind,
    output logic [7:0] msg_status,
    output logic [6:0] msg_data1,
    output logic [6:0] msg_data2,
    output logic [1:0] msg_length,
    output logic       msg_error,
    output logic       overflow_error,
    output logic       last
);

    logic                 accept;
    logic                 pop;
    logic [1:0]           push_count;
    mbsp_pkg::dec_out_t   dec;
    mbsp_pkg::res_t       head;
    mbsp_pkg::fifo_stat_t stat;

    assign accept     = in_valid && !in_stall;
    assign pop        = out_valid && !out_stall;
    assign push_count = accept ? dec.count : 2'd0;

    mbsp_decoder u_decoder (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .rx_byte     (rx_byte),
        .rx_overflow (rx_overflow),
        .dec         (dec)
    );

    mbsp_result_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_count (push_count),
        .push_data  (dec),
        .pop        (pop),
        .head       (head),
        .stat       (stat)
    );

    assign in_stall       = stat.no_room;
    assign out_valid      = stat.not_empty;
    assign kind           = head.kind;
    assign msg_status     = head.status;
    assign msg_data1      = head.data1;
    assign msg_data2      = head.data2;
    assign msg_length     = head.length;
    assign msg_error      = head.msg_err;
    assign overflow_error = head.ovf_err;
    assign last           = head.last;

    // only an aborted sysex gives two results, and the abort byte comes first
    assert property (@(posedge clk) disable iff (!rst_n)
        dec.count == 2'd2 |-> dec.first.kind == mbsp_pkg::KIND_SYSEX &&
                              dec.first.status == mbsp_pkg::SYSEX_ABORT)
        else $error("two results without sysex abort");

    assert property (@(posedge clk) disable iff (!rst_n)
        dec.count != 2'd3)
        else $error("decoder result count out of range");

    // a realtime byte always leaves a result behind
    assert property (@(posedge clk) disable iff (!rst_n)
        accept && rx_byte >= mbsp_pkg::REALTIME_MIN |=> out_valid)
        else $error("realtime byte lost");

    // input stalls only while results are held
    assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid)
        else $error("stall with empty result queue");

endmodule
